### hw/rtl/indexed_vector_buffer_core_defines.svh
// assertion macros for the indexed vector buffer
`ifndef INDEXED_VECTOR_BUFFER_CORE_DEFINES_SVH
`define INDEXED_VECTOR_BUFFER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define IVB_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define IVB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the following cycle
`define IVB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define IVB_ASSERT(lbl, clk, rst_n, expr, msg)
`define IVB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define IVB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/ivb_pkg.sv
// types and codes shared by the indexed vector buffer
`timescale 1ns / 1ps

package ivb_pkg;

	localparam int WORD_W   = 32;
	localparam int INDEX_W  = 7;
	localparam int COUNT_W  = 7;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_GET    = 3'd4
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADIDX = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SHIFT_DOWN
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [WORD_W-1:0]   value;
	} cell_ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0]           cmd;
		logic [INDEX_W-1:0]         index;
		logic signed [WORD_W-1:0]   value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]   data;
		logic [STATUS_W-1:0]        status;
		logic [COUNT_W-1:0]         count;
	} rsp_item_t;

endpackage

### hw/rtl/ivb_cell.sv
// one storage cell of the shifting word chain
`timescale 1ns / 1ps

module ivb_cell import ivb_pkg::*; #(
	parameter int POS = 0,
	parameter int KW  = 7
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [KW-1:0]       key,
	input  logic [WORD_W-1:0]   prev_word,
	input  logic [WORD_W-1:0]   next_word,
	output logic [WORD_W-1:0]   word,
	output logic [WORD_W-1:0]   rd_word
);

	localparam logic [KW-1:0] MY_POS = KW'(POS);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD: begin
				if (key == MY_POS) begin
					word_q <= ctl.value;
				end else if (key < MY_POS) begin
					word_q <= prev_word;
				end
			end
			CELL_SHIFT_DOWN: begin
				if (key <= MY_POS) begin
					word_q <= next_word;
				end
			end
			default: begin
			end
		endcase
	end

	assign word    = word_q;
	assign rd_word = (key == MY_POS) ? word_q : '0;

endmodule

### hw/rtl/indexed_vector_buffer_core.sv
// indexed vector buffer: bounded word list with push, pop, insert, delete and get
//
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_ready | cmd_item (cmd, index, value)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_item (data, status, count)
//
// every cell picks its next word from its own position against the key, so
// a whole shift lands in all cells at once
// a new command is taken in the same cycle as the waiting response is taken
// reset clears the count and the response valid; stored words start undefined
// a stalled response holds off new commands until it is taken
`timescale 1ns / 1ps
`include "indexed_vector_buffer_core_defines.svh"

module indexed_vector_buffer_core import ivb_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp_item
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     fill_next;
	logic [IW-1:0]     fill_x;
	logic [IW-1:0]     idx_x;
	logic [IW-1:0]     key;
	logic              accept;
	logic              full;
	logic              empty;
	cell_ctl_t         ctl;
	cell_op_t          op;
	logic              take_rd;
	status_t           status;
	logic [WORD_W-1:0] rd_word;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	logic [WORD_W-1:0] cell_word [CAPACITY];
	logic [WORD_W-1:0] cell_rd [CAPACITY];

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign full      = (fill_q == CW'(CAPACITY));
	assign empty     = (fill_q == '0);
	assign fill_x    = IW'(fill_q);
	assign idx_x     = IW'(cmd_item.index);

	always_comb begin
		op        = CELL_HOLD;
		key       = idx_x;
		fill_next = fill_q;
		take_rd   = 1'b0;
		status    = ST_OK;
		case (cmd_item.cmd)
			CMD_PUSH: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					op        = CELL_LOAD;
					key       = fill_x;
					fill_next = fill_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					key       = fill_x - IW'(1);
					take_rd   = 1'b1;
					fill_next = fill_q - CW'(1);
				end
			end
			CMD_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (idx_x > fill_x) begin
					status = ST_BADIDX;
				end else begin
					op        = CELL_LOAD;
					fill_next = fill_q + CW'(1);
				end
			end
			CMD_DELETE: begin
				if (idx_x >= fill_x) begin
					status = ST_BADIDX;
				end else begin
					op        = CELL_SHIFT_DOWN;
					take_rd   = 1'b1;
					fill_next = fill_q - CW'(1);
				end
			end
			CMD_GET: begin
				if (idx_x >= fill_x) begin
					status = ST_BADIDX;
				end else begin
					take_rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ctl.op    = accept ? op : CELL_HOLD;
		ctl.value = cmd_item.value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] prev_w;
		logic [WORD_W-1:0] next_w;
		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_prev
			assign prev_w = cell_word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = cell_word[i];
		end else begin : g_next
			assign next_w = cell_word[i+1];
		end
		ivb_cell #(
			.POS (i),
			.KW  (IW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.key       (key),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[i]),
			.rd_word   (cell_rd[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.data   <= take_rd ? $signed(rd_word) : '0;
			rsp_q.status <= status;
			rsp_q.count  <= COUNT_W'(IW'(fill_next));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	`IVB_ASSERT(a_fill_bound, clk, arst_n, fill_q <= CW'(CAPACITY), "count above capacity")
	`IVB_ASSERT_NEXT(a_rsp_follows, clk, arst_n, accept, rsp_valid_q, "no response after transaction")
	`IVB_ASSERT_SAME(a_count_tracks, clk, arst_n, rsp_valid_q, rsp_q.count == COUNT_W'(IW'(fill_q)), "response count differs from fill")
	`IVB_ASSERT_SAME(a_full_refusal, clk, arst_n, rsp_valid_q && (rsp_q.status == ST_FULL), full, "full status while not full")
	`IVB_ASSERT_SAME(a_error_zero, clk, arst_n, rsp_valid_q && (rsp_q.status != ST_OK), rsp_q.data == '0, "error response with data")

endmodule
